[design/edr_pkg.sv]
// shared types, constants and helpers for the elitist diversity replacement block
package edr_pkg;

  localparam int unsigned PopSize  = 16;
  localparam int unsigned NumGenes = 16;

  localparam int unsigned RowIdxW  = (PopSize > 1) ? $clog2(PopSize) : 1;
  localparam int unsigned GeneIdxW = (NumGenes > 1) ? $clog2(NumGenes) : 1;
  localparam int unsigned PopDepth = PopSize * NumGenes;
  localparam int unsigned PopAw    = (PopDepth > 1) ? $clog2(PopDepth) : 1;
  localparam int unsigned MaxIter  = (PopSize > NumGenes) ? PopSize : NumGenes;
  localparam int unsigned CntW     = $clog2(MaxIter + 1);

  localparam int unsigned GeneW    = 16;
  localparam int unsigned FitW     = 32;
  localparam int unsigned DiffW    = GeneW + 1;
  localparam int unsigned SqW      = 2 * GeneW + 1;
  localparam int unsigned DistW    = SqW + $clog2(NumGenes + 1);
  localparam int unsigned ThrW     = 40;
  localparam int unsigned CmpW     = (DistW > ThrW) ? DistW : ThrW;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned EliteW   = 4;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = ThrW;

  typedef enum logic [2:0] {
    OpWrGene  = 3'd0,
    OpWrFit   = 3'd1,
    OpElite   = 3'd2,
    OpWrOff   = 3'd3,
    OpCommit  = 3'd4,
    OpRdGene  = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusLimit   = 2'd1,
    StatusRefused = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReplaceLimit       = 1'd0,
    CfgDiversityThreshold = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    opcode_e                   opcode;
    logic [3:0]                row;
    logic [3:0]                col;
    logic signed [GeneW-1:0]   gene_value;
    logic signed [FitW-1:0]    fitness_value;
  } in_item_t;

  typedef struct packed {
    logic signed [GeneW-1:0]   gene_out;
    logic [EliteW-1:0]         best_row;
    logic                      replaced;
    status_e                   status;
  } out_item_t;

  // flat population address of gene g in row r
  function automatic logic [PopAw-1:0] pop_addr(input logic [RowIdxW-1:0]  r,
                                                input logic [GeneIdxW-1:0] g);
    logic [PopAw-1:0] base;
    base = PopAw'(PopAw'(r) * PopAw'(NumGenes));
    return PopAw'(base + PopAw'(g));
  endfunction

endpackage

[design/elitist_diversity_replacement.sv]
// top level: population, fitness and offspring stores with elitism and diversity commit
//
// Each item gives exactly one result item. Elitism scans the fitness memory one row a
// cycle and then copies the elite row into row 0 one gene a cycle. An honoured commit
// streams the target row and the offspring row through a subtract, square and
// accumulate pipeline, and writes the offspring back into the target row when the
// distance passes. The population memory has a single read port. A new item is taken
// as soon as the previous one has handed its result to the output register, even while
// that result still waits there.
module elitist_diversity_replacement (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  edr_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output edr_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [edr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [edr_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StDist,
    StCopy,
    StResp
  } state_e;

  // stores
  logic signed [edr_pkg::GeneW-1:0] pop_mem [edr_pkg::PopDepth];
  logic signed [edr_pkg::FitW-1:0]  fit_mem [edr_pkg::PopSize];
  logic signed [edr_pkg::GeneW-1:0] off_mem [edr_pkg::NumGenes];

  logic                             pop_we;
  logic [edr_pkg::PopAw-1:0]        pop_waddr;
  logic signed [edr_pkg::GeneW-1:0] pop_wdata;
  logic [edr_pkg::PopAw-1:0]        pop_raddr;
  logic signed [edr_pkg::GeneW-1:0] pop_rdata;

  logic                             fit_we;
  logic [edr_pkg::RowIdxW-1:0]      fit_addr;
  logic signed [edr_pkg::FitW-1:0]  fit_rdata;

  logic                             off_we;
  logic [edr_pkg::GeneIdxW-1:0]     off_waddr;
  logic [edr_pkg::GeneIdxW-1:0]     off_raddr;
  logic signed [edr_pkg::GeneW-1:0] off_rdata;

  // control and datapath registers
  state_e                           state_q;
  logic [3:0]                       row_q;
  logic [edr_pkg::CntW-1:0]         cnt_q;
  logic                             rd_v_q;
  logic [edr_pkg::CntW-1:0]         rd_idx_q;
  logic [edr_pkg::RowIdxW-1:0]      best_q;
  logic signed [edr_pkg::FitW-1:0]  bestf_q;
  logic                             src_off_q;
  logic [edr_pkg::RowIdxW-1:0]      src_row_q;
  logic [edr_pkg::RowIdxW-1:0]      dst_row_q;
  logic                             diff_v_q;
  logic signed [edr_pkg::DiffW-1:0] diff_q;
  logic signed [edr_pkg::DiffW-1:0] diff_d;
  logic                             sq_v_q;
  logic [edr_pkg::SqW-1:0]          sq_q;
  logic signed [2*edr_pkg::DiffW-1:0] prod;
  logic [edr_pkg::DistW-1:0]        acc_q;
  logic [edr_pkg::LimitW-1:0]       commit_count_q;
  logic [edr_pkg::EliteW-1:0]       elite_row_q;
  logic [edr_pkg::LimitW-1:0]       replace_limit_q;
  logic [edr_pkg::ThrW-1:0]         threshold_q;
  logic signed [edr_pkg::GeneW-1:0] res_gene_q;
  logic                             res_replaced_q;
  edr_pkg::status_e                 res_status_q;
  logic                             rd_ok_q;
  logic                             out_valid_q;
  edr_pkg::out_item_t               out_item_q;

  logic in_acc;
  logic row_ok;
  logic col_ok;
  logic scan_issue;
  logic gene_issue;
  logic dist_done;
  logic pass_test;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign row_ok     = 32'(in_item_i.row) < edr_pkg::PopSize;
  assign col_ok     = 32'(in_item_i.col) < edr_pkg::NumGenes;
  assign scan_issue = 32'(cnt_q) < edr_pkg::PopSize;
  assign gene_issue = 32'(cnt_q) < edr_pkg::NumGenes;
  assign dist_done  = !gene_issue && !rd_v_q && !diff_v_q && !sq_v_q;
  assign pass_test  = edr_pkg::CmpW'(acc_q) > edr_pkg::CmpW'(threshold_q);

  assign diff_d = edr_pkg::DiffW'(off_rdata) - edr_pkg::DiffW'(pop_rdata);
  assign prod   = diff_q * diff_q;

  // memory port steering
  always_comb begin
    pop_we    = 1'b0;
    pop_waddr = edr_pkg::pop_addr(edr_pkg::RowIdxW'(in_item_i.row),
                                  edr_pkg::GeneIdxW'(in_item_i.col));
    pop_wdata = in_item_i.gene_value;
    pop_raddr = edr_pkg::pop_addr(edr_pkg::RowIdxW'(in_item_i.row),
                                  edr_pkg::GeneIdxW'(in_item_i.col));
    fit_we    = 1'b0;
    fit_addr  = edr_pkg::RowIdxW'(in_item_i.row);
    off_we    = 1'b0;
    off_waddr = edr_pkg::GeneIdxW'(in_item_i.col);
    off_raddr = edr_pkg::GeneIdxW'(in_item_i.col);
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          pop_we = (in_item_i.opcode == edr_pkg::OpWrGene) && row_ok && col_ok;
          fit_we = (in_item_i.opcode == edr_pkg::OpWrFit) && row_ok;
          off_we = (in_item_i.opcode == edr_pkg::OpWrOff) && col_ok;
        end
      end
      StScan: begin
        fit_addr = edr_pkg::RowIdxW'(cnt_q);
      end
      StDist: begin
        pop_raddr = edr_pkg::pop_addr(edr_pkg::RowIdxW'(row_q), edr_pkg::GeneIdxW'(cnt_q));
        off_raddr = edr_pkg::GeneIdxW'(cnt_q);
      end
      StCopy: begin
        pop_raddr = edr_pkg::pop_addr(src_row_q, edr_pkg::GeneIdxW'(cnt_q));
        off_raddr = edr_pkg::GeneIdxW'(cnt_q);
        // write lands in the cycle after the read of the same gene
        pop_we    = rd_v_q;
        pop_waddr = edr_pkg::pop_addr(dst_row_q, edr_pkg::GeneIdxW'(rd_idx_q));
        pop_wdata = src_off_q ? off_rdata : pop_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_we) begin
      pop_mem[pop_waddr] <= pop_wdata;
    end
    pop_rdata <= pop_mem[pop_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fit_we) begin
      fit_mem[fit_addr] <= in_item_i.fitness_value;
    end
    fit_rdata <= fit_mem[fit_addr];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_waddr] <= in_item_i.gene_value;
    end
    off_rdata <= off_mem[off_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      row_q           <= '0;
      cnt_q           <= '0;
      rd_v_q          <= 1'b0;
      rd_idx_q        <= '0;
      best_q          <= '0;
      bestf_q         <= '0;
      src_off_q       <= 1'b0;
      src_row_q       <= '0;
      dst_row_q       <= '0;
      diff_v_q        <= 1'b0;
      diff_q          <= '0;
      sq_v_q          <= 1'b0;
      sq_q            <= '0;
      acc_q           <= '0;
      commit_count_q  <= '0;
      elite_row_q     <= '0;
      replace_limit_q <= edr_pkg::LimitW'(1);
      threshold_q     <= '0;
      res_gene_q      <= '0;
      res_replaced_q  <= 1'b0;
      res_status_q    <= edr_pkg::StatusOk;
      rd_ok_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      out_item_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (edr_pkg::cfg_reg_e'(cfg_idx_i))
          edr_pkg::CfgReplaceLimit:       replace_limit_q <= cfg_data_i[edr_pkg::LimitW-1:0];
          edr_pkg::CfgDiversityThreshold: threshold_q     <= cfg_data_i[edr_pkg::ThrW-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      rd_v_q   <= 1'b0;
      rd_idx_q <= cnt_q;
      // subtract, square, accumulate pipeline for the distance pass
      diff_v_q <= rd_v_q && (state_q == StDist);
      diff_q   <= diff_d;
      sq_v_q   <= diff_v_q;
      sq_q     <= prod[edr_pkg::SqW-1:0];
      if (sq_v_q) begin
        acc_q <= edr_pkg::DistW'(acc_q + edr_pkg::DistW'(sq_q));
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            row_q          <= in_item_i.row;
            cnt_q          <= '0;
            acc_q          <= '0;
            res_gene_q     <= '0;
            res_replaced_q <= 1'b0;
            res_status_q   <= edr_pkg::StatusOk;
            rd_ok_q        <= row_ok && col_ok;
            unique case (in_item_i.opcode)
              edr_pkg::OpRdGene: state_q <= StRead;
              edr_pkg::OpElite:  state_q <= StScan;
              edr_pkg::OpCommit: begin
                if (in_item_i.row == '0 || !row_ok) begin
                  res_status_q <= edr_pkg::StatusRefused;
                  state_q      <= StResp;
                end else if (commit_count_q >= replace_limit_q) begin
                  res_status_q <= edr_pkg::StatusLimit;
                  state_q      <= StResp;
                end else begin
                  commit_count_q <= commit_count_q + 1'b1;
                  state_q        <= StDist;
                end
              end
              default: state_q <= StResp;
            endcase
          end
        end
        StRead: begin
          res_gene_q <= rd_ok_q ? pop_rdata : '0;
          state_q    <= StResp;
        end
        StScan: begin
          if (scan_issue) begin
            cnt_q  <= cnt_q + 1'b1;
            rd_v_q <= 1'b1;
          end
          // first strict minimum wins
          if (rd_v_q && (rd_idx_q == '0 || fit_rdata < bestf_q)) begin
            bestf_q <= fit_rdata;
            best_q  <= edr_pkg::RowIdxW'(rd_idx_q);
          end
          if (!scan_issue && !rd_v_q) begin
            elite_row_q    <= edr_pkg::EliteW'(best_q);
            commit_count_q <= '0;
            src_off_q      <= 1'b0;
            src_row_q      <= best_q;
            dst_row_q      <= '0;
            cnt_q          <= '0;
            state_q        <= StCopy;
          end
        end
        StDist: begin
          if (gene_issue) begin
            cnt_q  <= cnt_q + 1'b1;
            rd_v_q <= 1'b1;
          end
          if (dist_done) begin
            if (pass_test) begin
              res_replaced_q <= 1'b1;
              src_off_q      <= 1'b1;
              dst_row_q      <= edr_pkg::RowIdxW'(row_q);
              cnt_q          <= '0;
              state_q        <= StCopy;
            end else begin
              state_q <= StResp;
            end
          end
        end
        StCopy: begin
          if (gene_issue) begin
            cnt_q  <= cnt_q + 1'b1;
            rd_v_q <= 1'b1;
          end
          if (!gene_issue && !rd_v_q) begin
            state_q <= StResp;
          end
        end
        StResp: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q         <= 1'b1;
            out_item_q.gene_out <= res_gene_q;
            out_item_q.best_row <= elite_row_q;
            out_item_q.replaced <= res_replaced_q;
            out_item_q.status   <= res_status_q;
            state_q             <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[design/edr_checker.sv]
// port-level checker for the elitist diversity replacement block, with its bind
module edr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input edr_pkg::out_item_t  out_item_o
);

  logic [2:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken whose result has not yet left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result item without an accepted item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many items in flight");

  a_replace_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.replaced |-> out_item_o.status == edr_pkg::StatusOk)
    else $error("replacement reported with a refusing status");

endmodule

bind elitist_diversity_replacement edr_checker u_edr_checker (.*);

[bench/testbench.sv]
// testbench for the elitist diversity replacement block: scoreboard, stimulus and checks
module testbench;
  import edr_pkg::*;

  localparam int unsigned DrainCycles = 64;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 110;
  localparam logic [2:0]  OpSpare6    = 3'd6;
  localparam logic [2:0]  OpSpare7    = 3'd7;

  class replacement_scoreboard;
    logic signed [GeneW-1:0] population [PopSize*NumGenes];
    logic signed [FitW-1:0]  fitness [PopSize];
    logic signed [GeneW-1:0] offspring [NumGenes];
    logic [LimitW-1:0]       commit_cnt;
    logic [EliteW-1:0]       elite;
    logic [LimitW-1:0]       limit;
    logic [ThrW-1:0]         threshold;
    out_item_t               awaited_results[$];
    int                      errors;

    function new();
      commit_cnt = '0;
      elite      = '0;
      limit      = LimitW'(1);
      threshold  = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgReplaceLimit:       limit = value[LimitW-1:0];
        CfgDiversityThreshold: threshold = value[ThrW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t item);
      out_item_t         res;
      int                base;
      int                best;
      int                diff;
      longint unsigned   sq_sum;
      res        = '0;
      res.status = StatusOk;
      base       = int'(item.row) * NumGenes;
      case (item.opcode)
        OpWrGene: population[base + int'(item.col)] = item.gene_value;
        OpWrFit:  fitness[item.row] = item.fitness_value;
        OpElite: begin
          // first strict minimum wins ties
          best = 0;
          for (int i = 1; i < PopSize; i++)
            if (fitness[i] < fitness[best]) best = i;
          for (int j = 0; j < NumGenes; j++)
            population[j] = population[best * NumGenes + j];
          elite      = EliteW'(best);
          commit_cnt = '0;
        end
        OpWrOff: offspring[item.col] = item.gene_value;
        OpCommit: begin
          if (item.row == '0) begin
            res.status = StatusRefused;
          end else if (commit_cnt >= limit) begin
            res.status = StatusLimit;
          end else begin
            commit_cnt++;
            sq_sum = 0;
            for (int j = 0; j < NumGenes; j++) begin
              diff = int'(offspring[j]) - int'(population[base + j]);
              sq_sum += longint'(diff) * longint'(diff);
            end
            if (sq_sum > {24'd0, threshold}) begin
              for (int j = 0; j < NumGenes; j++) population[base + j] = offspring[j];
              res.replaced = 1'b1;
            end
          end
        end
        OpRdGene: res.gene_out = population[base + int'(item.col)];
        default: ;
      endcase
      res.best_row = elite;
      awaited_results.push_back(res);
    endfunction

    function void flag_field(string name, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.gene_out !== want.gene_out) flag_field("gene_out", want.gene_out, got.gene_out);
        if (got.best_row !== want.best_row) flag_field("best_row", want.best_row, got.best_row);
        if (got.replaced !== want.replaced) flag_field("replaced", want.replaced, got.replaced);
        if (got.status !== want.status) flag_field("status", want.status, got.status);
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  replacement_scoreboard sb;
  int                    n_sent = 0;
  logic                  calm;

  assign calm = (n_sent >= 600) && (n_sent < 720);

  always #5 clk = ~clk;

  elitist_diversity_replacement uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic signed [GeneW-1:0] pick_gene();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
      1:       return GeneW'(int'($urandom_range(16)) - 8);
      default: return GeneW'($urandom);
    endcase
  endfunction

  function automatic logic signed [FitW-1:0] pick_fitness();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      1:       return FitW'(int'($urandom_range(6)) - 3);  // small range gives ties
      default: return FitW'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(opcode_e op, logic [3:0] row, logic [3:0] col,
                                         logic signed [GeneW-1:0] gene,
                                         logic signed [FitW-1:0] fit);
    in_item_t item;
    item.opcode        = op;
    item.row           = row;
    item.col           = col;
    item.gene_value    = gene;
    item.fitness_value = fit;
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    int       sel;
    item = make_item(OpWrGene, 4'($urandom), 4'($urandom), pick_gene(), pick_fitness());
    sel  = $urandom_range(99);
    if (sel < 15) item.opcode = OpWrGene;
    else if (sel < 25) item.opcode = OpWrFit;
    else if (sel < 32) item.opcode = OpElite;
    else if (sel < 52) item.opcode = OpWrOff;
    else if (sel < 72) begin
      item.opcode = OpCommit;
      // keep most commits off the protected elite row
      if (item.row == '0 && $urandom_range(3) != 0) item.row = 4'($urandom_range(15, 1));
    end
    else if (sel < 96) item.opcode = OpRdGene;
    else item.opcode = opcode_e'($urandom_range(1) ? OpSpare6 : OpSpare7);
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(item);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off, checks every accepted item
  initial begin : result_side
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (!held && n_sent >= 350) begin
        held      = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [ThrW-1:0]   thr;
    logic [LimitW-1:0] lim;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: commit to the elite row, spare opcodes, gene and fitness extremes
    send_item(make_item(OpCommit, 4'd0, 4'd3, pick_gene(), pick_fitness()));
    send_item(make_item(opcode_e'(OpSpare6), 4'd5, 4'd9, pick_gene(), pick_fitness()));
    send_item(make_item(opcode_e'(OpSpare7), 4'd10, 4'd2, pick_gene(), pick_fitness()));
    send_item(make_item(OpWrGene, 4'd3, 4'd0, 16'sh8000, pick_fitness()));
    send_item(make_item(OpWrGene, 4'd15, 4'd15, 16'sh7FFF, pick_fitness()));
    send_item(make_item(OpWrGene, 4'd0, 4'd7, 16'sh0000, pick_fitness()));
    send_item(make_item(OpRdGene, 4'd3, 4'd0, pick_gene(), pick_fitness()));
    send_item(make_item(OpRdGene, 4'd15, 4'd15, pick_gene(), pick_fitness()));
    send_item(make_item(OpRdGene, 4'd0, 4'd7, pick_gene(), pick_fitness()));
    send_item(make_item(OpWrFit, 4'd0, 4'd1, pick_gene(), 32'sh8000_0000));
    send_item(make_item(OpWrFit, 4'd15, 4'd4, pick_gene(), 32'sh7FFF_FFFF));
    send_item(make_item(OpWrOff, 4'd6, 4'd0, 16'sh8000, pick_fitness()));
    send_item(make_item(OpWrOff, 4'd6, 4'd15, 16'sh7FFF, pick_fitness()));

    // a zero limit turns every commit away
    settle();
    write_reg(CfgReplaceLimit, CfgDataW'(0));
    send_item(make_item(OpCommit, 4'd1, 4'd0, pick_gene(), pick_fitness()));
    send_item(make_item(OpCommit, 4'd15, 4'd0, pick_gene(), pick_fitness()));

    // fill every store before anything reads it
    settle();
    write_reg(CfgReplaceLimit, CfgDataW'(255));
    for (int r = 0; r < PopSize; r++)
      for (int c = 0; c < NumGenes; c++)
        send_item(make_item(OpWrGene, 4'(r), 4'(c), pick_gene(), pick_fitness()));
    for (int r = 0; r < PopSize; r++)
      send_item(make_item(OpWrFit, 4'(r), 4'($urandom), pick_gene(), pick_fitness()));
    for (int c = 0; c < NumGenes; c++)
      send_item(make_item(OpWrOff, 4'($urandom), 4'(c), pick_gene(), pick_fitness()));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lim = 8'd255; thr = '0; end
        1: begin lim = 8'd1; thr = 40'hFF_FFFF_FFFF; end
        2: begin lim = 8'd3; thr = (40'd1 << 32) + 40'($urandom) * 40'd3; end
        3: begin lim = 8'd0; thr = 40'd1 << 20; end
        4: begin lim = 8'($urandom_range(20, 2)); thr = 40'd1 << 33; end
        default: begin lim = 8'd255; thr = 40'($urandom_range(5000)); end
      endcase
      settle();
      write_reg(CfgReplaceLimit, CfgDataW'(lim));
      write_reg(CfgDiversityThreshold, CfgDataW'(thr));
      send_item(make_item(OpElite, 4'($urandom), 4'($urandom), pick_gene(), pick_fitness()));
      for (int k = 0; k < PhaseItems; k++) send_item(random_item());
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
design/edr_pkg.sv
design/elitist_diversity_replacement.sv
design/edr_checker.sv
bench/testbench.sv
